FILE: rtl/core/fcp_pkg.sv
// shared types, widths and status codes of the friction cone projection
`timescale 1ns / 1ps

package fcp_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int LANES       = 3;
   localparam int WORD_W      = 32;
   localparam int COEF_W      = 19;
   localparam int FN_W        = WORD_W - 1;
   localparam int LIM_W       = COEF_W + FN_W;
   localparam int HALF_W      = (LIM_W + 1) / 2;
   localparam int HPROD_W     = 2 * HALF_W;
   localparam int NUM_W       = 64;
   localparam int REM_W       = 32;
   localparam int SQ_W        = 64;
   localparam int LIM2_W      = 2 * LIM_W;
   localparam int MRN_SH_W    = SQ_W + 2 * FRAC_BITS;
   localparam int CMP_W       = (MRN_SH_W > LIM2_W) ? MRN_SH_W : LIM2_W;
   localparam int SCL_W       = FRAC_BITS + 1;
   localparam int PROD_W      = WORD_W + SCL_W;
   localparam int QDIV_STEPS  = WORD_W + FRAC_BITS;
   localparam int SDIV_STEPS  = LIM_W;
   localparam int SQRT_STEPS  = SQ_W / 2;
   localparam int SQ_IDX_W    = $clog2(SQRT_STEPS);
   localparam int SH_W        = SQ_IDX_W + 1;

   localparam logic signed [WORD_W-1:0] SAT_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic signed [WORD_W-1:0] SAT_MIN = {1'b1, {(WORD_W-1){1'b0}}};
   localparam logic [SCL_W-1:0]         SCL_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   typedef enum logic [1:0] {
      ST_SEPARATED = 2'd0,
      ST_INSIDE    = 2'd1,
      ST_SCALED    = 2'd2,
      ST_INVALID   = 2'd3
   } fcp_status_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] rhs_normal;
      logic signed [WORD_W-1:0] rhs_tan1;
      logic signed [WORD_W-1:0] rhs_tan2;
      logic signed [WORD_W-1:0] diag_normal;
      logic signed [WORD_W-1:0] diag_tan1;
      logic signed [WORD_W-1:0] diag_tan2;
   } fcp_req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] force_normal;
      logic signed [WORD_W-1:0] force_tan1;
      logic signed [WORD_W-1:0] force_tan2;
      fcp_status_type           contact_status;
   } fcp_rsp_type;

   // flags that ride along the quotient cells
   typedef struct packed {
      logic [LANES-1:0] neg;
      logic             sep;
      logic             inv;
   } fcp_qtag_type;

   // per-contact context after the quotients
   typedef struct packed {
      fcp_status_type           code;
      logic [LIM_W-1:0]         lim;
      logic signed [WORD_W-1:0] fn;
      logic signed [WORD_W-1:0] f1;
      logic signed [WORD_W-1:0] f2;
      logic [WORD_W-1:0]        m1;
      logic [WORD_W-1:0]        m2;
   } fcp_side_type;

endpackage

FILE: rtl/core/fcp_div_cell.sv
// one restoring division step: shifts in a numerator bit and produces one quotient bit
`timescale 1ns / 1ps

module fcp_div_cell import fcp_pkg::*; (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num_in,
   input  logic [REM_W-1:0] rem_in,
   input  logic [NUM_W-1:0] quo_in,
   input  logic [REM_W-1:0] den_in,
   output logic [NUM_W-1:0] num_out,
   output logic [REM_W-1:0] rem_out,
   output logic [NUM_W-1:0] quo_out,
   output logic [REM_W-1:0] den_out
);

   logic [REM_W:0]   trial;
   logic             fits;
   logic [NUM_W-1:0] num_ff, num_in_w, quo_ff, quo_ff_in;
   logic [REM_W-1:0] rem_ff, rem_ff_in, den_ff;

   always_comb begin
      trial     = {rem_in, num_in[NUM_W-1]};
      fits      = trial >= {1'b0, den_in};
      num_in_w  = {num_in[NUM_W-2:0], 1'b0};
      rem_ff_in = fits ? REM_W'(trial - {1'b0, den_in}) : trial[REM_W-1:0];
      quo_ff_in = {quo_in[NUM_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= num_in_w;
         rem_ff <= rem_ff_in;
         quo_ff <= quo_ff_in;
         den_ff <= den_in;
      end
   end

   assign num_out = num_ff;
   assign rem_out = rem_ff;
   assign quo_out = quo_ff;
   assign den_out = den_ff;

endmodule

FILE: rtl/core/fcp_sqrt_cell.sv
// one step of the bit-pair integer square root
`timescale 1ns / 1ps

module fcp_sqrt_cell import fcp_pkg::*; (
   input  logic                clock,
   input  logic                en,
   input  logic [SQ_IDX_W-1:0] idx,
   input  logic [SQ_W-1:0]     v_in,
   input  logic [SQ_W-1:0]     r_in,
   output logic [SQ_W-1:0]     v_out,
   output logic [SQ_W-1:0]     r_out
);

   logic [SH_W-1:0] sh;
   logic [SQ_W-1:0] bit_w, trial, v_ff, v_ff_in, r_ff, r_ff_in;
   logic            fits;

   always_comb begin
      sh      = SH_W'(2 * (SQRT_STEPS - 1)) - SH_W'({idx, 1'b0});
      bit_w   = SQ_W'(1) << sh;
      trial   = r_in + bit_w;
      fits    = v_in >= trial;
      v_ff_in = fits ? v_in - trial : v_in;
      r_ff_in = fits ? (r_in >> 1) + bit_w : r_in >> 1;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff <= v_ff_in;
         r_ff <= r_ff_in;
      end
   end

   assign v_out = v_ff;
   assign r_out = r_ff;

endmodule

FILE: rtl/core/friction_cone_projection_3d.sv
// top level: quotient cells, cone test, root cells, scale-factor cells and scaling
`timescale 1ns / 1ps

// Friction cone projection for one 3D contact per word, signed Q16.16.
// req channel: req_valid / req_stall carry one contact (three rhs values and
// three diagonal entries) in req_data. rsp channel: rsp_valid / rsp_stall
// carry the projected forces and a contact status in rsp_data.
// csr channel: csr_valid / csr_ready write the friction coefficient; csr_ready
// is always high, and a write is expected only while no contact is in flight.
// A word passes from acceptance to its result word through 48 quotient
// cells (one quotient bit each, three lanes side by side), five stages for the
// saturation, products and cone test, 32 square-root cells, 50 cells that
// divide out the scale factor, and three stages for the clamp, the scaling and
// the output register.
// Throughput is one word per cycle. The whole pipe moves together: when a
// result word sits in the output register and rsp_stall is high, the pipe
// holds and req_stall is raised; otherwise a new word is taken every cycle.
// A synchronous reset clears all valid bits and sets the coefficient to 0.
module friction_cone_projection_3d import fcp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fcp_req_type       req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fcp_rsp_type       rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [COEF_W-1:0] csr_data
);

   localparam int STAGES = QDIV_STEPS + 5 + SQRT_STEPS + SDIV_STEPS + 2;

   logic adv, accept;
   logic [COEF_W-1:0] coef_ff;
   logic [STAGES-1:0] vld_ff, vld_ff_in;
   logic rsp_valid_ff;
   fcp_rsp_type rsp_data_ff, rsp_data_ff_in;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign accept    = req_valid && adv;
   assign req_stall = !adv;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign vld_ff_in = {vld_ff[STAGES-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else if (csr_valid) begin
         coef_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= vld_ff_in;
         rsp_valid_ff <= vld_ff[STAGES-1];
      end
   end

   // ---------------- quotient cells ----------------
   logic signed [WORD_W-1:0] rhs_w [LANES];
   logic signed [WORD_W-1:0] diag_w [LANES];
   logic [NUM_W-1:0] qd_num [LANES][QDIV_STEPS+1];
   logic [REM_W-1:0] qd_rem [LANES][QDIV_STEPS+1];
   logic [NUM_W-1:0] qd_quo [LANES][QDIV_STEPS+1];
   logic [REM_W-1:0] qd_den [LANES][QDIV_STEPS+1];
   fcp_qtag_type qtag_ff [QDIV_STEPS];
   fcp_qtag_type qtag_in;

   assign rhs_w[0]  = req_data.rhs_normal;
   assign rhs_w[1]  = req_data.rhs_tan1;
   assign rhs_w[2]  = req_data.rhs_tan2;
   assign diag_w[0] = req_data.diag_normal;
   assign diag_w[1] = req_data.diag_tan1;
   assign diag_w[2] = req_data.diag_tan2;

   always_comb begin
      qtag_in.sep = !rhs_w[0][WORD_W-1] && (rhs_w[0] != '0);
      qtag_in.inv = 1'b0;
      for (int l = 0; l < LANES; l++) begin
         qtag_in.neg[l] = !rhs_w[l][WORD_W-1] && (rhs_w[l] != '0);
         if (diag_w[l][WORD_W-1] || diag_w[l] == '0) begin
            qtag_in.inv = 1'b1;
         end
      end
   end

   genvar gl, gk;
   generate
      for (gl = 0; gl < LANES; gl++) begin : g_qlane
         // magnitude shifted up by the fraction bits, left aligned
         assign qd_num[gl][0] = {(rhs_w[gl][WORD_W-1] ? WORD_W'(-rhs_w[gl]) : rhs_w[gl]),
                                 {(NUM_W-WORD_W){1'b0}}};
         assign qd_rem[gl][0] = '0;
         assign qd_quo[gl][0] = '0;
         assign qd_den[gl][0] = diag_w[gl];
         for (gk = 0; gk < QDIV_STEPS; gk++) begin : g_qcell
            fcp_div_cell u_cell (
               .clock   (clock),
               .en      (adv),
               .num_in  (qd_num[gl][gk]),
               .rem_in  (qd_rem[gl][gk]),
               .quo_in  (qd_quo[gl][gk]),
               .den_in  (qd_den[gl][gk]),
               .num_out (qd_num[gl][gk+1]),
               .rem_out (qd_rem[gl][gk+1]),
               .quo_out (qd_quo[gl][gk+1]),
               .den_out (qd_den[gl][gk+1])
            );
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (adv) begin
         qtag_ff[0] <= qtag_in;
         for (int k = 1; k < QDIV_STEPS; k++) begin
            qtag_ff[k] <= qtag_ff[k-1];
         end
      end
   end

   // ---------------- saturation ----------------
   fcp_qtag_type q_tag;
   logic signed [WORD_W-1:0] q_f [LANES];
   logic [WORD_W-1:0] q_m [LANES];
   fcp_side_type q_side_ff, q_side_ff_in;

   assign q_tag = qtag_ff[QDIV_STEPS-1];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (!q_tag.neg[l]) begin
            if (|qd_quo[l][QDIV_STEPS][NUM_W-1:WORD_W-1]) begin
               q_f[l] = SAT_MAX;
            end else begin
               q_f[l] = qd_quo[l][QDIV_STEPS][WORD_W-1:0];
            end
            q_m[l] = q_f[l];
         end else if ((|qd_quo[l][QDIV_STEPS][NUM_W-1:WORD_W]) ||
                      (qd_quo[l][QDIV_STEPS][WORD_W-1] &&
                       (|qd_quo[l][QDIV_STEPS][WORD_W-2:0]))) begin
            q_f[l] = SAT_MIN;
            q_m[l] = SAT_MIN;
         end else begin
            q_m[l] = qd_quo[l][QDIV_STEPS][WORD_W-1:0];
            q_f[l] = -qd_quo[l][QDIV_STEPS][WORD_W-1:0];
         end
      end
      q_side_ff_in.code = q_tag.sep ? ST_SEPARATED : (q_tag.inv ? ST_INVALID : ST_INSIDE);
      q_side_ff_in.lim  = '0;
      q_side_ff_in.fn   = q_f[0];
      q_side_ff_in.f1   = q_f[1];
      q_side_ff_in.f2   = q_f[2];
      q_side_ff_in.m1   = q_m[1];
      q_side_ff_in.m2   = q_m[2];
   end

   // ---------------- squares and cone limit ----------------
   fcp_side_type m_side_ff, m_side_ff_in, a_side_ff, b_side_ff, c_side_ff, c_side_ff_in;
   logic [SQ_W-1:0] sq1_ff, sq1_ff_in, sq2_ff, sq2_ff_in;
   logic [SQ_W-1:0] mrn_a_ff, mrn_a_ff_in, mrn_b_ff, mrn_c_ff;
   logic [HPROD_W-1:0] hh_ff, hh_ff_in, hl_ff, hl_ff_in, ll_ff, ll_ff_in;
   logic [LIM2_W-1:0] lim2_ff, lim2_ff_in;
   logic [LIM_W-HALF_W-1:0] lim_hi;
   logic [HALF_W-1:0] lim_lo;
   logic cone_out;

   always_comb begin
      m_side_ff_in     = q_side_ff;
      m_side_ff_in.lim = LIM_W'(coef_ff) * LIM_W'(q_side_ff.fn[FN_W-1:0]);
      sq1_ff_in        = SQ_W'(q_side_ff.m1) * SQ_W'(q_side_ff.m1);
      sq2_ff_in        = SQ_W'(q_side_ff.m2) * SQ_W'(q_side_ff.m2);

      // lim squared from half-width partial products
      lim_hi      = m_side_ff.lim[LIM_W-1:HALF_W];
      lim_lo      = m_side_ff.lim[HALF_W-1:0];
      mrn_a_ff_in = sq1_ff + sq2_ff;
      hh_ff_in    = HPROD_W'(lim_hi) * HPROD_W'(lim_hi);
      hl_ff_in    = HPROD_W'(lim_hi) * HPROD_W'(lim_lo);
      ll_ff_in    = HPROD_W'(lim_lo) * HPROD_W'(lim_lo);

      lim2_ff_in  = (LIM2_W'(hh_ff) << (2 * HALF_W)) + (LIM2_W'(hl_ff) << (HALF_W + 1))
                    + LIM2_W'(ll_ff);

      cone_out    = (CMP_W'(mrn_b_ff) << (2 * FRAC_BITS)) > CMP_W'(lim2_ff);
      c_side_ff_in = b_side_ff;
      if (b_side_ff.code == ST_INSIDE && cone_out) begin
         c_side_ff_in.code = ST_SCALED;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         q_side_ff <= q_side_ff_in;
         m_side_ff <= m_side_ff_in;
         sq1_ff    <= sq1_ff_in;
         sq2_ff    <= sq2_ff_in;
         a_side_ff <= m_side_ff;
         mrn_a_ff  <= mrn_a_ff_in;
         hh_ff     <= hh_ff_in;
         hl_ff     <= hl_ff_in;
         ll_ff     <= ll_ff_in;
         b_side_ff <= a_side_ff;
         mrn_b_ff  <= mrn_a_ff;
         lim2_ff   <= lim2_ff_in;
         c_side_ff <= c_side_ff_in;
         mrn_c_ff  <= mrn_b_ff;
      end
   end

   // ---------------- square root cells ----------------
   logic [SQ_W-1:0] sq_v [SQRT_STEPS+1];
   logic [SQ_W-1:0] sq_r [SQRT_STEPS+1];
   fcp_side_type sside_ff [SQRT_STEPS];

   assign sq_v[0] = mrn_c_ff;
   assign sq_r[0] = '0;

   generate
      for (gk = 0; gk < SQRT_STEPS; gk++) begin : g_scell
         fcp_sqrt_cell u_cell (
            .clock (clock),
            .en    (adv),
            .idx   (SQ_IDX_W'(gk)),
            .v_in  (sq_v[gk]),
            .r_in  (sq_r[gk]),
            .v_out (sq_v[gk+1]),
            .r_out (sq_r[gk+1])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (adv) begin
         sside_ff[0] <= c_side_ff;
         for (int k = 1; k < SQRT_STEPS; k++) begin
            sside_ff[k] <= sside_ff[k-1];
         end
      end
   end

   // ---------------- scale factor cells: lim / root ----------------
   logic [NUM_W-1:0] sd_num [SDIV_STEPS+1];
   logic [REM_W-1:0] sd_rem [SDIV_STEPS+1];
   logic [NUM_W-1:0] sd_quo [SDIV_STEPS+1];
   logic [REM_W-1:0] sd_den [SDIV_STEPS+1];
   fcp_side_type dside_ff [SDIV_STEPS];

   assign sd_num[0] = {sside_ff[SQRT_STEPS-1].lim, {(NUM_W-LIM_W){1'b0}}};
   assign sd_rem[0] = '0;
   assign sd_quo[0] = '0;
   assign sd_den[0] = sq_r[SQRT_STEPS][REM_W-1:0];

   generate
      for (gk = 0; gk < SDIV_STEPS; gk++) begin : g_dcell
         fcp_div_cell u_cell (
            .clock   (clock),
            .en      (adv),
            .num_in  (sd_num[gk]),
            .rem_in  (sd_rem[gk]),
            .quo_in  (sd_quo[gk]),
            .den_in  (sd_den[gk]),
            .num_out (sd_num[gk+1]),
            .rem_out (sd_rem[gk+1]),
            .quo_out (sd_quo[gk+1]),
            .den_out (sd_den[gk+1])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (adv) begin
         dside_ff[0] <= sside_ff[SQRT_STEPS-1];
         for (int k = 1; k < SDIV_STEPS; k++) begin
            dside_ff[k] <= dside_ff[k-1];
         end
      end
   end

   // ---------------- clamp, scale, output ----------------
   fcp_side_type s_side_ff, p_side_ff;
   logic [SCL_W-1:0] s_ff, s_ff_in;
   logic [PROD_W-1:0] p1_ff, p1_ff_in, p2_ff, p2_ff_in;
   logic [WORD_W-1:0] o_t1, o_t2;

   always_comb begin
      if (sd_quo[SDIV_STEPS] > NUM_W'(SCL_ONE)) begin
         s_ff_in = SCL_ONE;
      end else begin
         s_ff_in = sd_quo[SDIV_STEPS][SCL_W-1:0];
      end
      p1_ff_in = PROD_W'(s_side_ff.m1) * PROD_W'(s_ff);
      p2_ff_in = PROD_W'(s_side_ff.m2) * PROD_W'(s_ff);

      o_t1 = p1_ff[FRAC_BITS +: WORD_W];
      o_t2 = p2_ff[FRAC_BITS +: WORD_W];
      rsp_data_ff_in.contact_status = p_side_ff.code;
      unique case (p_side_ff.code)
         ST_INSIDE: begin
            rsp_data_ff_in.force_normal = p_side_ff.fn;
            rsp_data_ff_in.force_tan1   = p_side_ff.f1;
            rsp_data_ff_in.force_tan2   = p_side_ff.f2;
         end
         ST_SCALED: begin
            rsp_data_ff_in.force_normal = p_side_ff.fn;
            rsp_data_ff_in.force_tan1   = p_side_ff.f1[WORD_W-1] ? -o_t1 : o_t1;
            rsp_data_ff_in.force_tan2   = p_side_ff.f2[WORD_W-1] ? -o_t2 : o_t2;
         end
         default: begin
            rsp_data_ff_in.force_normal = '0;
            rsp_data_ff_in.force_tan1   = '0;
            rsp_data_ff_in.force_tan2   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s_side_ff   <= dside_ff[SDIV_STEPS-1];
         s_ff        <= s_ff_in;
         p_side_ff   <= s_side_ff;
         p1_ff       <= p1_ff_in;
         p2_ff       <= p2_ff_in;
         rsp_data_ff <= rsp_data_ff_in;
      end
   end

endmodule

FILE: test/friction_cone_projection_3d_tb.sv
// testbench of the friction cone projection: random and directed contacts checked against a predictor
`timescale 1ns / 1ps

module friction_cone_projection_3d_tb;
   import fcp_pkg::*;

   class cone_scoreboard;
      fcp_rsp_type expected_forces[$];
      logic [COEF_W-1:0] mu;
      int errors;

      function new();
         mu = '0;
         errors = 0;
      endfunction

      // -(rhs << F) / diag, truncated toward zero, saturated to 32 bits
      function automatic longint divide_force(longint rhs, longint diag);
         longint q;
         q = (-rhs * (longint'(1) << FRAC_BITS)) / diag;
         if (q > 64'sd2147483647) q = 64'sd2147483647;
         if (q < -64'sd2147483648) q = -64'sd2147483648;
         return q;
      endfunction

      function automatic logic [63:0] root_floor(logic [63:0] v);
         logic [63:0] r;
         logic [63:0] b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function automatic longint shrink_tan(longint t, logic [63:0] s);
         logic [63:0] mag;
         logic [63:0] p;
         mag = (t < 0) ? 64'(-t) : 64'(t);
         p = (mag * s) >> FRAC_BITS;
         return (t < 0) ? -longint'(p) : longint'(p);
      endfunction

      function void note_contact(fcp_req_type w);
         fcp_rsp_type e;
         longint fn, f1, f2;
         logic [63:0] m1, m2, mrn, lim, r, s;
         logic [127:0] lhs, rhs2;
         fn = 0; f1 = 0; f2 = 0;
         if (w.rhs_normal > 0) begin
            e.contact_status = ST_SEPARATED;
         end else if (w.diag_normal <= 0 || w.diag_tan1 <= 0 || w.diag_tan2 <= 0) begin
            e.contact_status = ST_INVALID;
         end else begin
            fn = divide_force(w.rhs_normal, w.diag_normal);
            f1 = divide_force(w.rhs_tan1, w.diag_tan1);
            f2 = divide_force(w.rhs_tan2, w.diag_tan2);
            m1 = (f1 < 0) ? 64'(-f1) : 64'(f1);
            m2 = (f2 < 0) ? 64'(-f2) : 64'(f2);
            mrn = m1 * m1 + m2 * m2;
            lim = 64'(mu) * 64'(fn);
            lhs = {64'd0, mrn} << (2 * FRAC_BITS);
            rhs2 = {64'd0, lim} * {64'd0, lim};
            if (lhs > rhs2) begin
               r = root_floor(mrn);
               s = lim / r;
               if (s > (64'd1 << FRAC_BITS)) s = 64'd1 << FRAC_BITS;
               f1 = shrink_tan(f1, s);
               f2 = shrink_tan(f2, s);
               e.contact_status = ST_SCALED;
            end else begin
               e.contact_status = ST_INSIDE;
            end
         end
         e.force_normal = fn[31:0];
         e.force_tan1 = f1[31:0];
         e.force_tan2 = f2[31:0];
         expected_forces.push_back(e);
      endfunction

      function void check_word(fcp_rsp_type got);
         fcp_rsp_type e;
         if (expected_forces.size() == 0) begin
            $error("unexpected result word %h", got);
            errors++;
            return;
         end
         e = expected_forces.pop_front();
         if (got.force_normal !== e.force_normal) begin
            $error("force_normal: expected %h, got %h", e.force_normal, got.force_normal);
            errors++;
         end
         if (got.force_tan1 !== e.force_tan1) begin
            $error("force_tan1: expected %h, got %h", e.force_tan1, got.force_tan1);
            errors++;
         end
         if (got.force_tan2 !== e.force_tan2) begin
            $error("force_tan2: expected %h, got %h", e.force_tan2, got.force_tan2);
            errors++;
         end
         if (got.contact_status !== e.contact_status) begin
            $error("contact_status: expected %0d, got %0d", e.contact_status,
                   got.contact_status);
            errors++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   fcp_req_type       req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   fcp_rsp_type       rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [COEF_W-1:0] csr_data;

   cone_scoreboard sb = new();
   bit calm;
   bit hold_rx;

   friction_cone_projection_3d dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_word(rsp_data);
   end

   // result side stall pattern, with one long hold-off on request
   initial begin
      int n;
      wait (reset === 1'b0);
      forever begin
         n = calm ? 0 : $urandom_range(0, 18);
         if (hold_rx) begin
            hold_rx = 0;
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
         end else if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      #3000000;
      $display("Test completed with failures");
      $finish;
   end

   task automatic send_contact(fcp_req_type w);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_stall);
      sb.note_contact(w);
   endtask

   task automatic push_contact(int bn, int b1, int b2, int dn, int d1, int d2);
      fcp_req_type w;
      w = '{bn, b1, b2, dn, d1, d2};
      send_contact(w);
   endtask

   // drain the pipe, then write the coefficient while idle
   task automatic set_mu(logic [COEF_W-1:0] v);
      req_valid <= 1'b0;
      while (sb.expected_forces.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.mu = v;
   endtask

   function automatic int signed_span(int lim);
      int m;
      m = $urandom_range(0, lim);
      return $urandom_range(0, 1) ? -m : m;
   endfunction

   function automatic fcp_req_type random_contact();
      fcp_req_type w;
      int mode;
      mode = $urandom_range(0, 9);
      w.rhs_normal = -$urandom_range(0, 1 << 22);
      w.rhs_tan1 = signed_span(1 << 22);
      w.rhs_tan2 = signed_span(1 << 22);
      w.diag_normal = $urandom_range(1, 1 << 18);
      w.diag_tan1 = $urandom_range(1, 1 << 18);
      w.diag_tan2 = $urandom_range(1, 1 << 18);
      case (mode)
         0: w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
         1: w.rhs_normal = $urandom_range(1, 32'h7fffffff);
         2: begin
            case ($urandom_range(0, 2))
               0: w.diag_normal = -$urandom_range(0, 1 << 20);
               1: w.diag_tan1 = -$urandom_range(0, 1 << 20);
               default: w.diag_tan2 = -$urandom_range(0, 1 << 20);
            endcase
         end
         3: begin
            // wide values that reach saturation
            w.rhs_normal = -$urandom_range(0, 32'h7fffffff);
            w.rhs_tan1 = $urandom;
            w.rhs_tan2 = $urandom;
            w.diag_normal = $urandom_range(1, 1 << 10);
            w.diag_tan1 = $urandom_range(1, 32'h7fffffff);
            w.diag_tan2 = $urandom_range(1, 1 << 10);
         end
         default: ;
      endcase
      return w;
   endfunction

   initial begin
      logic [COEF_W-1:0] mus[4];
      clock = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      rsp_stall <= 1'b0;
      csr_valid <= 1'b0;
      csr_data <= '0;
      calm = 0;
      hold_rx = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero friction out of reset: any nonzero tangential value is scaled to nothing
      push_contact(-(5 << 16), 3 << 16, -(2 << 16), 1 << 16, 1 << 16, 1 << 16);
      push_contact(0, 1, -1, 1, 1, 1);
      push_contact(0, 0, 0, 1 << 16, 1 << 16, 1 << 16);

      set_mu(19'd65536);
      push_contact(1, 0, 0, -1, 0, 0);
      push_contact(32'h7fffffff, 5, 5, 1, 1, 1);
      push_contact(-1, 1, 1, 0, 1, 1);
      push_contact(-1, 1, 1, 1, -1, 1);
      push_contact(-1, 1, 1, 1, 1, 32'h80000000);
      push_contact(32'h80000000, 32'h7fffffff, 32'h80000000, 1, 1, 1);
      push_contact(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                   32'h7fffffff);
      push_contact(-(10 << 16), -(3 << 16), 4 << 16, 1 << 16, 1 << 16, 1 << 16);
      push_contact(-(10 << 16), -(30 << 16), 40 << 16, 1 << 16, 1 << 16, 1 << 16);
      push_contact(-(5 << 16), 3 << 16, 4 << 16, 1 << 16, 1 << 16, 1 << 16);
      push_contact(0, 7 << 16, -(1 << 16), 1 << 16, 1 << 16, 1 << 16);
      push_contact(-(1 << 16), 32'h80000000, 0, 1 << 16, 1, 1);

      set_mu(19'd262144);
      push_contact(-(1 << 16), -(4 << 16), 1, 1 << 16, 1 << 16, 1 << 16);
      push_contact(32'h80000000, 32'h80000000, 32'h80000000, 1, 1, 1);

      mus[0] = 19'd262144;
      mus[1] = 19'd0;
      mus[2] = 19'd32768;
      mus[3] = 19'($urandom_range(0, 262144));
      for (int p = 0; p < 4; p++) begin
         if (p != 0) set_mu(mus[p]);
         calm = (p == 2);
         if (p == 1) hold_rx = 1;
         for (int i = 0; i < 190; i++) send_contact(random_contact());
      end
      calm = 0;
      req_valid <= 1'b0;

      while (sb.expected_forces.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/fcp_pkg.sv
rtl/core/fcp_div_cell.sv
rtl/core/fcp_sqrt_cell.sv
rtl/core/friction_cone_projection_3d.sv
test/friction_cone_projection_3d_tb.sv
